/* design/es2cal_pkg.sv */
// shared types, constants and table functions for the epoch to calendar converter
package es2cal_pkg;

	localparam int DefaultBaseYear = 1970;

	localparam int YearW   = 12;
	localparam int MonthW  = 4;
	localparam int DayW    = 5;
	localparam int HourW   = 5;
	localparam int MinuteW = 6;
	localparam int SecondW = 6;

	localparam int SecsW   = 32;
	localparam int DaysW   = 16;
	localparam int LenW    = 9;

	localparam logic [SecsW-1:0] SecPerDay  = 32'd86400;
	localparam logic [SecsW-1:0] SecPerHour = 32'd3600;
	localparam logic [SecsW-1:0] SecPerMin  = 32'd60;

	// shift counts for the restoring divide steps (top quotient bit index)
	localparam logic [3:0] DayTopBit  = 4'd15;
	localparam logic [3:0] HourTopBit = 4'd4;
	localparam logic [3:0] MinTopBit  = 4'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAY,
		ST_HOUR,
		ST_MIN,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	function automatic logic [LenW-1:0] year_len(input logic leap);
		year_len = leap ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [LenW-1:0] month_len(input logic [MonthW-1:0] mon,
		input logic leap);
		case (mon)
			4'd1:    month_len = 9'd31;
			4'd2:    month_len = leap ? 9'd29 : 9'd28;
			4'd3:    month_len = 9'd31;
			4'd4:    month_len = 9'd30;
			4'd5:    month_len = 9'd31;
			4'd6:    month_len = 9'd30;
			4'd7:    month_len = 9'd31;
			4'd8:    month_len = 9'd31;
			4'd9:    month_len = 9'd30;
			4'd10:   month_len = 9'd31;
			4'd11:   month_len = 9'd30;
			4'd12:   month_len = 9'd31;
			default: month_len = 9'd31;
		endcase
	endfunction

endpackage

/* design/epoch_seconds_to_calendar.sv */
// top level: seconds since base year to gregorian date and time of day
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------------
//  in       | in_valid / in_ready          | epoch_seconds[31:0]
//  out      | out_valid / out_ready        | year, month, day, hour, minute, second
//
// after acceptance one request runs 16 day-divide steps, 5 hour steps, 6 minute steps,
// Y whole years (up to 136) and M whole months (up to 11), all through the single
// 32-bit subtract/compare unit, then passes through the DONE state
// in_ready is high only while the sequencer is idle
// the finished result sits in an output register, so a new request may start while
// the previous result is still waiting for out_ready
// reset clears the sequencer and the output valid flag; datapath registers are not reset
module epoch_seconds_to_calendar #(
	parameter int BASE_YEAR_VALUE = es2cal_pkg::DefaultBaseYear
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [es2cal_pkg::SecsW-1:0]      epoch_seconds,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [es2cal_pkg::YearW-1:0]      year,
	output logic [es2cal_pkg::MonthW-1:0]     month,
	output logic [es2cal_pkg::DayW-1:0]       day,
	output logic [es2cal_pkg::HourW-1:0]      hour,
	output logic [es2cal_pkg::MinuteW-1:0]    minute,
	output logic [es2cal_pkg::SecondW-1:0]    second
);
	import es2cal_pkg::*;

	// leap rule residues of the base year, worked out at elaboration
	localparam logic [1:0] BaseMod4   = 2'(BASE_YEAR_VALUE % 4);
	localparam logic [6:0] BaseMod100 = 7'(BASE_YEAR_VALUE % 100);
	localparam logic [8:0] BaseMod400 = 9'(BASE_YEAR_VALUE % 400);
	localparam logic [YearW-1:0] BaseYear = YearW'(BASE_YEAR_VALUE);

	state_t state_q, state_d;

	// working registers
	logic [SecsW-1:0]   acc_q;        // remainder / remaining day count
	logic [3:0]         cnt_q;        // divide step bit index
	logic [DaysW-1:0]   days_q;       // whole days since base
	logic [YearW-1:0]   year_q;
	logic [1:0]         y4_q;         // year mod 4
	logic [6:0]         y100_q;       // year mod 100
	logic [8:0]         y400_q;       // year mod 400
	logic [MonthW-1:0]  month_q;
	logic [HourW-1:0]   hour_q;
	logic [MinuteW-1:0] min_q;
	logic [SecondW-1:0] sec_q;

	// output register
	logic               out_valid_q;
	logic [YearW-1:0]   out_year_q;
	logic [MonthW-1:0]  out_month_q;
	logic [DayW-1:0]    out_day_q;
	logic [HourW-1:0]   out_hour_q;
	logic [MinuteW-1:0] out_min_q;
	logic [SecondW-1:0] out_sec_q;

	// shared subtract / compare unit
	logic [SecsW-1:0] sub;
	logic [SecsW:0]   diff;
	logic             ge;
	logic             leap;
	logic             accept;
	logic             out_free;
	logic             last_step;

	assign leap      = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign last_step = (cnt_q == 4'd0);

	// subtrahend chosen by phase: shifted divisor for the divides, a length otherwise
	always_comb begin
		case (state_q)
			ST_DAY:   sub = SecPerDay << cnt_q;
			ST_HOUR:  sub = SecPerHour << cnt_q;
			ST_MIN:   sub = SecPerMin << cnt_q;
			ST_YEAR:  sub = {{(SecsW-LenW){1'b0}}, year_len(leap)};
			ST_MONTH: sub = {{(SecsW-LenW){1'b0}}, month_len(month_q, leap)};
			default:  sub = '0;
		endcase
	end

	assign diff = {1'b0, acc_q} - {1'b0, sub};
	assign ge   = !diff[SecsW];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DAY;
				end
			end
			ST_DAY: begin
				if (last_step) begin
					state_d = ST_HOUR;
				end
			end
			ST_HOUR: begin
				if (last_step) begin
					state_d = ST_MIN;
				end
			end
			ST_MIN: begin
				if (last_step) begin
					state_d = ST_YEAR;
				end
			end
			ST_YEAR: begin
				if (!ge) begin
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				if (!ge) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: cnt_q <= DayTopBit;
				ST_DAY:  cnt_q <= last_step ? HourTopBit : cnt_q - 4'd1;
				ST_HOUR: cnt_q <= last_step ? MinTopBit : cnt_q - 4'd1;
				ST_MIN:  cnt_q <= last_step ? cnt_q : cnt_q - 4'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					acc_q <= epoch_seconds;
				end
				year_q  <= BaseYear;
				y4_q    <= BaseMod4;
				y100_q  <= BaseMod100;
				y400_q  <= BaseMod400;
				month_q <= MonthW'(1);
			end
			ST_DAY: begin
				// restoring divide by 86400, one quotient bit a cycle
				days_q <= {days_q[DaysW-2:0], ge};
				if (ge) begin
					acc_q <= diff[SecsW-1:0];
				end
			end
			ST_HOUR: begin
				hour_q <= {hour_q[HourW-2:0], ge};
				if (ge) begin
					acc_q <= diff[SecsW-1:0];
				end
			end
			ST_MIN: begin
				min_q <= {min_q[MinuteW-2:0], ge};
				if (last_step) begin
					// remainder is the second; day count moves into the accumulator
					sec_q <= ge ? diff[SecondW-1:0] : acc_q[SecondW-1:0];
					acc_q <= {{(SecsW-DaysW){1'b0}}, days_q};
				end else if (ge) begin
					acc_q <= diff[SecsW-1:0];
				end
			end
			ST_YEAR: begin
				// peel whole years, keeping the leap residues in step
				if (ge) begin
					acc_q  <= diff[SecsW-1:0];
					year_q <= year_q + YearW'(1);
					y4_q   <= y4_q + 2'd1;
					y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
					y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
				end
			end
			ST_MONTH: begin
				if (ge) begin
					acc_q   <= diff[SecsW-1:0];
					month_q <= month_q + MonthW'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_year_q  <= year_q;
					out_month_q <= month_q;
					out_day_q   <= acc_q[DayW-1:0] + DayW'(1);
					out_hour_q  <= hour_q;
					out_min_q   <= min_q;
					out_sec_q   <= sec_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign year      = out_year_q;
	assign month     = out_month_q;
	assign day       = out_day_q;
	assign hour      = out_hour_q;
	assign minute    = out_min_q;
	assign second    = out_sec_q;

endmodule

/* tb/sv/epoch_seconds_to_calendar_tb.sv */
// testbench for the epoch seconds to calendar converter, self-checking against its own date predictor
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

	import es2cal_pkg::*;

	localparam int BaseYear   = DefaultBaseYear;
	localparam int RandItems  = 1930;
	// no idling while the last requests go through
	localparam int TailItems  = 150;
	// room for every request at its slowest, plus the longest gap and stall for each
	localparam int CycleLimit = 1600000;
	localparam int DrainWait  = 200;

	typedef struct packed {
		logic [YearW-1:0]   year;
		logic [MonthW-1:0]  month;
		logic [DayW-1:0]    day;
		logic [HourW-1:0]   hour;
		logic [MinuteW-1:0] minute;
		logic [SecondW-1:0] second;
	} calendar_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [SecsW-1:0]  epoch_seconds = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [YearW-1:0]  year;
	logic [MonthW-1:0] month;
	logic [DayW-1:0]   day;
	logic [HourW-1:0]  hour;
	logic [MinuteW-1:0] minute;
	logic [SecondW-1:0] second;

	logic [SecsW-1:0] pending_secs[$];   // requests not yet presented
	calendar_t        expected_dates[$]; // predicted dates, oldest first
	int               mismatches = 0;
	int               cycles = 0;
	int               gap_left = 0;
	int               stall_left = 0;
	logic             calm = 1'b0;

	epoch_seconds_to_calendar u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.epoch_seconds (epoch_seconds),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// gregorian rule: every fourth year, but centuries only when divisible by 400
	function automatic bit is_leap_year(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int days_in_month(input int m, input bit leap);
		case (m)
			2:          return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:    return 31;
		endcase
	endfunction

	// predicted date and time of day for a count of seconds since the base year
	function automatic calendar_t calendar_of(input logic [SecsW-1:0] secs);
		int unsigned days;
		int unsigned tod;
		int unsigned yr;
		int unsigned mon;
		int unsigned len;
		calendar_t   c;
		days = secs / 86400;
		tod  = secs % 86400;
		yr   = BaseYear;
		// peel off whole years
		while (days >= (is_leap_year(yr) ? 366 : 365)) begin
			days = days - (is_leap_year(yr) ? 366 : 365);
			yr++;
		end
		// then whole months, february stretched in leap years
		mon = 1;
		len = days_in_month(mon, is_leap_year(yr));
		while (mon < 12 && days >= len) begin
			days = days - len;
			mon++;
			len = days_in_month(mon, is_leap_year(yr));
		end
		c.year   = yr[YearW-1:0];
		c.month  = mon[MonthW-1:0];
		c.day    = days[DayW-1:0] + DayW'(1);
		c.hour   = HourW'(tod / 3600);
		c.minute = MinuteW'((tod % 3600) / 60);
		c.second = SecondW'(tod % 60);
		return c;
	endfunction

	// seconds at midnight of a given date, wide enough to spot values past 32 bits
	function automatic longint midnight_of(input int y, input int m, input int d);
		longint days;
		int     yy;
		int     mm;
		days = 0;
		for (yy = BaseYear; yy < y; yy++)
			days += is_leap_year(yy) ? 366 : 365;
		for (mm = 1; mm < m; mm++)
			days += days_in_month(mm, is_leap_year(y));
		days += d - 1;
		return days * 86400;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// driver: presents pending requests, with random bursts of idle cycles between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			epoch_seconds <= '0;
			gap_left      <= 0;
			calm          <= 1'b0;
		end else begin
			calm <= (pending_secs.size() < TailItems);
			// a held request only moves on once it is taken
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_secs.size() != 0) begin
					epoch_seconds <= pending_secs.pop_front();
					in_valid      <= 1'b1;
					if (!calm && $urandom_range(0, 2) == 0)
						gap_left <= $urandom_range(1, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predicts each accepted request, stalls the result side, checks results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_dates.push_back(calendar_of(epoch_seconds));
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					mismatches++;
					$display("%0t: result %0d-%0d-%0d %0d:%0d:%0d with no request outstanding",
						$time, year, month, day, hour, minute, second);
				end else begin
					calendar_t want;
					want = expected_dates.pop_front();
					check_field("year", int'(want.year), int'(year));
					check_field("month", int'(want.month), int'(month));
					check_field("day", int'(want.day), int'(day));
					check_field("hour", int'(want.hour), int'(hour));
					check_field("minute", int'(want.minute), int'(minute));
					check_field("second", int'(want.second), int'(second));
				end
			end
			if (stall_left != 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 2) == 0)
					stall_left <= $urandom_range(1, 4);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int     n;
		int     kind;
		int     y;
		int     m;
		int     d;
		longint cand;

		// directed: range ends, day and year edges, leap february, century rules
		pending_secs.push_back(32'h0000_0000);
		pending_secs.push_back(32'hFFFF_FFFF);
		pending_secs.push_back(32'd86399);
		pending_secs.push_back(32'd86400);
		pending_secs.push_back(32'(midnight_of(1971, 1, 1) - 1));
		pending_secs.push_back(32'(midnight_of(1971, 1, 1)));
		pending_secs.push_back(32'(midnight_of(1972, 1, 31) + 86399));
		// first of february in a leap year
		pending_secs.push_back(32'(midnight_of(1972, 2, 1)));
		pending_secs.push_back(32'(midnight_of(1972, 2, 29) + 86399));
		pending_secs.push_back(32'(midnight_of(1972, 3, 1)));
		pending_secs.push_back(32'(midnight_of(1972, 12, 31)));
		pending_secs.push_back(32'(midnight_of(1973, 2, 28) + 86399));
		// 2000 is a leap year, 2100 is not
		pending_secs.push_back(32'(midnight_of(2000, 2, 29)));
		pending_secs.push_back(32'(midnight_of(2000, 3, 1) - 1));
		pending_secs.push_back(32'(midnight_of(2000, 12, 31) + 43200));
		pending_secs.push_back(32'(midnight_of(2100, 2, 28) + 86399));
		pending_secs.push_back(32'(midnight_of(2100, 3, 1)));
		pending_secs.push_back(32'(midnight_of(2106, 1, 1)));
		pending_secs.push_back(32'(midnight_of(2038, 1, 19) + 3 * 3600 + 14 * 60 + 7));
		pending_secs.push_back(32'hAAAA_AAAA);
		pending_secs.push_back(32'h5555_5555);
		pending_secs.push_back(32'h8000_0000);
		pending_secs.push_back(32'h7FFF_FFFF);

		// random: whole range, month edges with a few seconds either side, random dates
		n = 0;
		while (n < RandItems) begin
			kind = $urandom_range(0, 9);
			y    = $urandom_range(BaseYear, BaseYear + 136);
			m    = $urandom_range(1, 12);
			if (kind < 4) begin
				cand = longint'($urandom);
			end else if (kind < 7) begin
				cand = midnight_of(y, m, 1) + longint'($urandom_range(0, 7)) - 4;
			end else begin
				d    = $urandom_range(1, days_in_month(m, is_leap_year(y)));
				cand = midnight_of(y, m, d) + longint'($urandom_range(0, 86399));
			end
			if (cand >= 0 && cand <= 64'hFFFF_FFFF) begin
				pending_secs.push_back(cand[SecsW-1:0]);
				n++;
			end
		end

		// hold reset low, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every request to be taken, then for every result
		while (pending_secs.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_dates.size() != 0)
			@(posedge clk);
		// catch any stray result after the last one
		repeat (DrainWait) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
design/es2cal_pkg.sv
design/epoch_seconds_to_calendar.sv
tb/sv/epoch_seconds_to_calendar_tb.sv
